@@ design/rtcp_compound_nack_extractor_macros.svh @@
// Assertion helpers used by the top-level extractor file.
`ifndef RTCP_COMPOUND_NACK_EXTRACTOR_MACROS_SVH
`define RTCP_COMPOUND_NACK_EXTRACTOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RCNX_ASSERT_IMPLIES(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RCNX_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ design/rcnx_pkg.sv @@
`default_nettype none

package rcnx_pkg;

   localparam logic [1:0]  SUPPORTED_VER   = 2'd2;
   localparam logic [7:0]  PT_RTPFB        = 8'd205;
   localparam logic [4:0]  FMT_GENERIC     = 5'd1;
   localparam logic [1:0]  FCI_START       = 2'd3;
   localparam logic [10:0] MAX_NACK_RESET  = 11'd256;

   localparam logic KIND_RESEND  = 1'b0;
   localparam logic KIND_DROPPED = 1'b1;

   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

   typedef struct packed {
      logic [31:0] word;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] seqno;
      logic        last_of_run;
   } rsp_type;

   // One classified word that produces results.
   typedef struct packed {
      logic        is_error;
      logic [15:0] pid;
      logic [15:0] blp;
   } job_type;

   typedef struct packed {
      logic valid;
      logic full;
   } job_stat_type;

   // Index of the lowest set bit; zero when none is set.
   function automatic logic [3:0] lowest_set_index(input logic [15:0] mask);
      logic [3:0] idx;
      idx = 4'd0;
      for (int i = 15; i >= 0; i--) begin
         if (mask[i]) begin
            idx = 4'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

@@ design/rcnx_front.sv @@
`default_nettype none

module rcnx_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire rcnx_pkg::req_type req_data,
   input  wire logic             csr_write,
   input  wire logic [10:0]      csr_wdata,
   output      logic             job_push,
   output      rcnx_pkg::job_type job_data
);
   import rcnx_pkg::*;

   logic        at_start_ff,   at_start_in;
   logic        expect_hdr_ff, expect_hdr_in;
   logic        halted_ff,     halted_in;
   logic [15:0] words_rem_ff,  words_rem_in;
   logic [1:0]  position_ff,   position_in;
   logic        nack_ff,       nack_in;
   logic [10:0] entries_ff,    entries_in;
   logic [10:0] max_entries_ff, max_entries_in;

   logic [31:0] w;
   logic [1:0]  pos_next;
   logic [15:0] rem_next;
   logic        bad_version;
   logic        take_fci;

   assign w           = req_data.word;
   assign pos_next    = (position_ff == FCI_START) ? FCI_START : position_ff + 2'd1;
   assign rem_next    = words_rem_ff - 16'd1;
   assign bad_version = at_start_ff && (w[31:30] != SUPPORTED_VER);
   assign take_fci    = nack_ff && (pos_next == FCI_START) && (entries_ff < max_entries_ff);

   always_comb begin
      at_start_in    = at_start_ff;
      expect_hdr_in  = expect_hdr_ff;
      halted_in      = halted_ff;
      words_rem_in   = words_rem_ff;
      position_in    = position_ff;
      nack_in        = nack_ff;
      entries_in     = entries_ff;
      max_entries_in = csr_write ? csr_wdata : max_entries_ff;
      job_push       = 1'b0;
      job_data.is_error = bad_version;
      job_data.pid      = bad_version ? 16'd0 : w[31:16];
      job_data.blp      = bad_version ? 16'd0 : w[15:0];

      if (accept) begin
         if (!halted_ff) begin
            if (expect_hdr_ff) begin
               at_start_in = 1'b0;
               if (bad_version) begin
                  job_push  = 1'b1;
                  halted_in = 1'b1;
               end else if (w[15:0] == 16'd0) begin
                  halted_in = 1'b1;
               end else begin
                  words_rem_in  = w[15:0];
                  position_in   = 2'd0;
                  nack_in       = (w[23:16] == PT_RTPFB) && (w[28:24] == FMT_GENERIC);
                  entries_in    = 11'd0;
                  expect_hdr_in = 1'b0;
               end
            end else begin
               position_in = pos_next;
               if (take_fci) begin
                  job_push   = 1'b1;
                  entries_in = entries_ff + 11'd1;
               end
               words_rem_in = rem_next;
               if (rem_next == 16'd0) begin
                  expect_hdr_in = 1'b1;
                  nack_in       = 1'b0;
               end
            end
         end
         if (req_data.last_word) begin
            at_start_in   = 1'b1;
            expect_hdr_in = 1'b1;
            halted_in     = 1'b0;
            words_rem_in  = 16'd0;
            position_in   = 2'd0;
            nack_in       = 1'b0;
            entries_in    = 11'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff    <= 1'b1;
         expect_hdr_ff  <= 1'b1;
         halted_ff      <= 1'b0;
         words_rem_ff   <= 16'd0;
         position_ff    <= 2'd0;
         nack_ff        <= 1'b0;
         entries_ff     <= 11'd0;
         max_entries_ff <= MAX_NACK_RESET;
      end else begin
         at_start_ff    <= at_start_in;
         expect_hdr_ff  <= expect_hdr_in;
         halted_ff      <= halted_in;
         words_rem_ff   <= words_rem_in;
         position_ff    <= position_in;
         nack_ff        <= nack_in;
         entries_ff     <= entries_in;
         max_entries_ff <= max_entries_in;
      end
   end

endmodule

`default_nettype wire

@@ design/rcnx_job_queue.sv @@
`default_nettype none

module rcnx_job_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rcnx_pkg::job_type  push_data,
   input  wire logic               pop,
   output      rcnx_pkg::job_type  head_data,
   output      rcnx_pkg::job_stat_type stat
);
   import rcnx_pkg::*;

   job_type              slot_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_PTR_W:0]   count_ff,  count_in;

   assign head_data  = slot_ff[rd_ptr_ff];
   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == (JOB_PTR_W+1)'(JOB_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + JOB_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + JOB_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (JOB_PTR_W+1)'(1);
         2'b01:   count_in = count_ff - (JOB_PTR_W+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ design/rcnx_back.sv @@
`default_nettype none

module rcnx_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rcnx_pkg::job_type      job_data,
   input  wire rcnx_pkg::job_stat_type job_stat,
   output      logic                   job_pop,
   output      logic                   rsp_empty,
   input  wire logic                   rsp_pop,
   output      rcnx_pkg::rsp_type      rsp_data
);
   import rcnx_pkg::*;

   // Expander state
   logic        busy_ff,  busy_in;
   logic        first_ff, first_in;
   logic        err_ff,   err_in;
   logic [15:0] pid_ff,   pid_in;
   logic [15:0] mask_ff,  mask_in;

   // Two-entry result queue
   rsp_type     ent_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff,  count_in;

   logic        out_pop;
   logic        emit;
   rsp_type     emit_data;
   logic [15:0] mask_next;
   logic [3:0]  bit_idx;

   assign out_pop   = rsp_pop && (count_ff != 2'd0);
   assign emit      = busy_ff && (count_ff != 2'd2);
   assign bit_idx   = lowest_set_index(mask_ff);
   assign mask_next = mask_ff & (mask_ff - 16'd1);

   always_comb begin
      emit_data.kind        = KIND_RESEND;
      emit_data.seqno       = pid_ff;
      emit_data.last_of_run = (mask_ff == 16'd0);
      if (err_ff) begin
         emit_data.kind        = KIND_DROPPED;
         emit_data.seqno       = 16'd0;
         emit_data.last_of_run = 1'b1;
      end else if (!first_ff) begin
         emit_data.seqno       = pid_ff + {12'd0, bit_idx} + 16'd1;
         emit_data.last_of_run = (mask_next == 16'd0);
      end
   end

   assign job_pop = job_stat.valid && (!busy_ff || (emit && emit_data.last_of_run));

   always_comb begin
      busy_in  = busy_ff;
      first_in = first_ff;
      err_in   = err_ff;
      pid_in   = pid_ff;
      mask_in  = mask_ff;
      if (emit) begin
         if (emit_data.last_of_run) begin
            busy_in = 1'b0;
         end else begin
            first_in = 1'b0;
            if (!first_ff) begin
               mask_in = mask_next;
            end
         end
      end
      if (job_pop) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         err_in   = job_data.is_error;
         pid_in   = job_data.pid;
         mask_in  = job_data.blp;
      end
   end

   always_comb begin
      wr_ptr_in = emit    ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = out_pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({emit, out_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_data  = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (emit) begin
         ent_ff[wr_ptr_ff] <= emit_data;
      end
      err_ff  <= err_in;
      pid_ff  <= pid_in;
      mask_ff <= mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         first_ff  <= 1'b0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         busy_ff   <= busy_in;
         first_ff  <= first_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ design/rtcp_compound_nack_extractor.sv @@
// Generic NACK extractor for compound RTCP datagrams. Push one 32-bit
// big-endian datagram word per request, with last_word set on the final word
// of each datagram. A datagram whose first header is not version 2 yields a
// single dropped result (kind 1, seqno 0) and the rest of it is ignored.
// Every FCI word of a transport-feedback generic NACK sub-packet, up to the
// limit held in the CSR (reset 256, 0 disables expansion), yields its packet
// ID and then PID+i+1 for each set BLP bit i in rising order; last_of_run
// marks the final result of that word. The front end accepts one word every
// cycle while its four-deep job queue has room; words that produce no
// results never enter the queue. The expander emits one result per cycle while
// its result queue has room, so an FCI word with k BLP bits set keeps it busy
// for 1+k results; under heavy NACK load the sustained input rate is set by
// that drain and by how fast the consumer pops. No clearing pass runs after
// reset. Write the CSR only while the block is idle; csr_ready is always high.

`default_nettype none

module rtcp_compound_nack_extractor (
   input  wire logic              clock,
   input  wire logic              reset,
   // Request side
   input  wire logic              push,
   output      logic              full,
   input  wire rcnx_pkg::req_type req_data,
   // Result side
   output      logic              empty,
   input  wire logic              pop,
   output      rcnx_pkg::rsp_type rsp_data,
   // CSR write channel
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [10:0]       csr_wdata
);
   import rcnx_pkg::*;

   `include "rtcp_compound_nack_extractor_macros.svh"

   logic         accept;
   logic         csr_write;
   logic         job_push;
   logic         job_pop;
   job_type      job_in;
   job_type      job_head;
   job_stat_type job_stat;

   // Take a request whenever the job queue has a free slot.
   assign full      = job_stat.full;
   assign accept    = push && !full;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Front: walk the sub-packets and classify each word.
   rcnx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .job_push  (job_push),
      .job_data  (job_in)
   );

   // Decouple the walk from the expansion.
   rcnx_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .head_data (job_head),
      .stat      (job_stat)
   );

   // Back: expand each job into results and hold them for the consumer.
   rcnx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (job_head),
      .job_stat  (job_stat),
      .job_pop   (job_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_data  (rsp_data)
   );

   // A dropped datagram reports as one lone result with a zero seqno.
   `RCNX_ASSERT_IMPLIES(a_drop_is_lone, !empty && rsp_data.kind == KIND_DROPPED, rsp_data.last_of_run && rsp_data.seqno == 16'd0, "dropped result is not a lone zero result")
   // The front never writes a job into a full queue.
   `RCNX_ASSERT_IMPLIES(a_no_overflow, job_push, !job_stat.full, "job queue overflow")
   // The expander only takes jobs that exist.
   `RCNX_ASSERT_IMPLIES(a_no_underflow, job_pop, job_stat.valid, "job queue underflow")
   // A job taken from a full queue frees room on the next cycle.
   `RCNX_ASSERT_NEXT(a_room_after_pop, job_pop && !job_push && job_stat.full, !full, "queue stays full after pop")

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

module tb;
   import rcnx_pkg::*;

   // Idle time a gap takes before a config write, and the settle time at the end.
   localparam int DRAIN_CYCLES = 12;
   // Cycles without any accepted request, result or config write before giving up.
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_WORDS = 310;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        push      = 1'b0;
   logic        full;
   req_type     req_data  = '0;
   logic        empty;
   logic        pop       = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_wdata = '0;

   rtcp_compound_nack_extractor dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   int errors     = 0;
   int words_sent = 0;
   // Percent chance per cycle that a side holds off; zero gives a stretch with no idling.
   int idle_pct   = 10;

   // Mirror of the walk state and the entry cap.
   logic        dgram_start    = 1'b1;
   logic        header_due     = 1'b1;
   logic        walk_halted    = 1'b0;
   logic [15:0] sub_words_left = '0;
   logic [15:0] sub_pos        = '0;
   logic        generic_nack   = 1'b0;
   logic [11:0] fci_expanded   = '0;
   logic [10:0] nack_cap       = MAX_NACK_RESET;

   // Resend and drop results predicted but not yet popped, oldest first.
   rsp_type nack_results_due[$];

   function automatic void restart_walk();
      dgram_start    = 1'b1;
      header_due     = 1'b1;
      walk_halted    = 1'b0;
      sub_words_left = '0;
      sub_pos        = '0;
      generic_nack   = 1'b0;
      fci_expanded   = '0;
   endfunction

   function automatic rsp_type make_result(input logic kind, input logic [15:0] seqno);
      rsp_type r;
      r.kind        = kind;
      r.seqno       = seqno;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   // Advance the walk by one datagram word and queue the results it causes.
   function automatic void expand_word(input req_type r);
      rsp_type     run[$];
      logic [15:0] pid;
      logic [15:0] blp;
      if (!walk_halted) begin
         if (header_due) begin
            // Only the first header of a datagram has its version checked.
            if (dgram_start && r.word[31:30] != SUPPORTED_VER) begin
               run.push_back(make_result(KIND_DROPPED, 16'd0));
               walk_halted = 1'b1;
            end else if (r.word[15:0] == 16'd0) begin
               walk_halted = 1'b1;
            end else begin
               sub_words_left = r.word[15:0];
               sub_pos        = '0;
               generic_nack   = r.word[23:16] == PT_RTPFB && r.word[28:24] == FMT_GENERIC;
               fci_expanded   = '0;
               header_due     = 1'b0;
            end
            dgram_start = 1'b0;
         end else begin
            sub_pos = sub_pos + 16'd1;
            // FCI words follow the sender and media SSRC words.
            if (generic_nack && sub_pos >= 16'(FCI_START) && fci_expanded < 12'(nack_cap)) begin
               pid = r.word[31:16];
               blp = r.word[15:0];
               run.push_back(make_result(KIND_RESEND, pid));
               for (int i = 0; i < 16; i++) begin
                  if (blp[i]) begin
                     run.push_back(make_result(KIND_RESEND, pid + 16'(i + 1)));
                  end
               end
               fci_expanded = fci_expanded + 12'd1;
            end
            sub_words_left = sub_words_left - 16'd1;
            if (sub_words_left == 16'd0) begin
               header_due   = 1'b1;
               generic_nack = 1'b0;
            end
         end
      end
      if (run.size() != 0) begin
         run[run.size() - 1].last_of_run = 1'b1;
      end
      foreach (run[i]) begin
         nack_results_due.push_back(run[i]);
      end
      if (r.last_word) begin
         restart_walk();
      end
   endfunction

   function automatic logic [31:0] make_header(input logic [1:0] ver, input logic pad,
                                               input logic [4:0] fmt, input logic [7:0] pt,
                                               input logic [15:0] len);
      return {ver, pad, fmt, pt, len};
   endfunction

   function automatic logic [31:0] random_fci();
      logic [15:0] blp;
      case ($urandom_range(3))
         0:       blp = '0;
         1:       blp = 16'd1 << $urandom_range(15);
         2:       blp = 16'($urandom);
         default: blp = 16'($urandom) & 16'($urandom);
      endcase
      return {16'($urandom), blp};
   endfunction

   // Send one datagram word as a request; hold push high straight into the next
   // request unless a random gap is taken.
   task automatic send_word(input logic [31:0] word, input logic last_word);
      while ($urandom_range(99) < idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= {word, last_word};
      do @(posedge clock); while (full);
      expand_word({word, last_word});
      words_sent++;
   endtask

   // Write the entry cap once the block has drained.
   task automatic write_nack_cap(input logic [10:0] cap);
      push <= 1'b0;
      while (nack_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      nack_cap = cap;
   endtask

   // Pop results at random and compare each with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (nack_results_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, got kind %0d seqno %h last %0d",
                        $time, rsp_data.kind, rsp_data.seqno, rsp_data.last_of_run);
               errors++;
            end else begin
               want = nack_results_due.pop_front();
               if (rsp_data.kind !== want.kind) begin
                  $display("%0t: kind mismatch, expected %0d, got %0d",
                           $time, want.kind, rsp_data.kind);
                  errors++;
               end
               if (rsp_data.seqno !== want.seqno) begin
                  $display("%0t: seqno mismatch, expected %h, got %h",
                           $time, want.seqno, rsp_data.seqno);
                  errors++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $display("%0t: last_of_run mismatch, expected %0d, got %0d",
                           $time, want.last_of_run, rsp_data.last_of_run);
                  errors++;
               end
            end
         end
         pop <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Watchdog: count cycles in which no request, result or config write moves.
   int stall_cycles = 0;
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Wrong version on the first header drops the datagram, later words ignored.
   task automatic test_version_drop();
      send_word(make_header(2'd1, 1'b0, FMT_GENERIC, PT_RTPFB, 16'd3), 1'b0);
      send_word(32'h1234_5678, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0010_0001, 1'b1);
      send_word(make_header(2'd3, 1'b1, 5'd31, 8'd255, 16'hFFFF), 1'b1);
      send_word(make_header(2'd0, 1'b0, 5'd0, 8'd0, 16'd0), 1'b1);
   endtask

   // Zero length stops the walk until the datagram ends.
   task automatic test_length_zero();
      send_word(make_header(SUPPORTED_VER, 1'b0, FMT_GENERIC, PT_RTPFB, 16'd0), 1'b0);
      send_word(make_header(SUPPORTED_VER, 1'b0, FMT_GENERIC, PT_RTPFB, 16'd3), 1'b0);
      send_word(32'hAAAA_5555, 1'b1);
   endtask

   // Generic NACK with wrapping sequence numbers, an empty BLP, and a second
   // sub-packet whose version is not checked.
   task automatic test_generic_nack();
      send_word(make_header(SUPPORTED_VER, 1'b1, FMT_GENERIC, PT_RTPFB, 16'd4), 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(make_header(2'd0, 1'b0, FMT_GENERIC, PT_RTPFB, 16'd3), 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'h8000_8001, 1'b1);
   endtask

   // NACK sub-packets too short to hold an FCI word, then other types skipped.
   task automatic test_short_and_other();
      send_word(make_header(SUPPORTED_VER, 1'b0, FMT_GENERIC, PT_RTPFB, 16'd1), 1'b0);
      send_word(32'h0001_FFFF, 1'b0);
      send_word(make_header(SUPPORTED_VER, 1'b0, FMT_GENERIC, PT_RTPFB, 16'd2), 1'b0);
      send_word(32'h0002_FFFF, 1'b0);
      send_word(32'h0003_FFFF, 1'b0);
      send_word(make_header(SUPPORTED_VER, 1'b0, 5'd2, PT_RTPFB, 16'd3), 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'h0004_0003, 1'b0);
      send_word(make_header(SUPPORTED_VER, 1'b0, FMT_GENERIC, 8'd206, 16'd3), 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'h0005_0003, 1'b1);
   endtask

   // A last word in the middle of a sub-packet ends the walk there.
   task automatic test_datagram_end();
      send_word(make_header(SUPPORTED_VER, 1'b0, FMT_GENERIC, PT_RTPFB, 16'd10), 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'h7000_0010, 1'b1);
      send_word(32'h7001_0001, 1'b1);
   endtask

   // Cap the FCI words expanded per sub-packet, including no expansion at all.
   task automatic test_entry_cap();
      logic [10:0] caps[4];
      caps = '{11'd1, 11'd0, 11'd2047, 11'd1024};
      foreach (caps[c]) begin
         write_nack_cap(caps[c]);
         send_word(make_header(SUPPORTED_VER, 1'b0, FMT_GENERIC, PT_RTPFB, 16'd5), 1'b0);
         send_word(32'h0, 1'b0);
         send_word(32'h0, 1'b0);
         send_word(32'h0100_0001, 1'b0);
         send_word(32'h0200_0002, 1'b0);
         send_word(32'h0300_0004, 1'b1);
      end
   endtask

   task automatic send_random_datagram();
      logic [31:0] words[$];
      logic [1:0]  ver;
      int          n_sub;
      int          len;
      int          pick;
      int          keep;
      n_sub = $urandom_range(1, 3);
      for (int s = 0; s < n_sub; s++) begin
         ver  = ($urandom_range(19) == 0) ? 2'($urandom) : SUPPORTED_VER;
         pick = $urandom_range(99);
         if (pick < 60) begin
            len = $urandom_range(1, 7);
            words.push_back(make_header(ver, 1'($urandom), FMT_GENERIC, PT_RTPFB, 16'(len)));
            for (int k = 0; k < len; k++) begin
               words.push_back(k < 2 ? 32'($urandom) : random_fci());
            end
         end else if (pick < 95) begin
            len = $urandom_range(1, 4);
            words.push_back(make_header(ver, 1'($urandom), 5'($urandom), 8'($urandom),
                                        16'(len)));
            for (int k = 0; k < len; k++) begin
               words.push_back($urandom);
            end
         end else begin
            words.push_back(make_header(ver, 1'($urandom), 5'($urandom), 8'($urandom),
                                        16'd0));
            words.push_back(random_fci());
         end
      end
      // Cut the datagram short now and then, or pad it with trailing words.
      pick = $urandom_range(99);
      if (pick < 10 && words.size() > 1) begin
         keep = $urandom_range(1, words.size() - 1);
         while (words.size() > keep) void'(words.pop_back());
      end else if (pick < 15) begin
         repeat ($urandom_range(1, 3)) words.push_back(random_fci());
      end
      foreach (words[i]) begin
         send_word(words[i], i == words.size() - 1);
      end
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         send_word($urandom, i == n - 1 || $urandom_range(7) == 0);
      end
   endtask

   task automatic test_random_traffic();
      int          first_word;
      int          next_cap_write;
      int          dgram;
      logic [10:0] cap;
      first_word     = words_sent;
      next_cap_write = words_sent + 60;
      dgram          = 0;
      while (words_sent < first_word + RANDOM_WORDS) begin
         // Hold both sides busy for one stretch of datagrams.
         idle_pct = (dgram >= 20 && dgram < 40) ? 0 : 10;
         if (words_sent >= next_cap_write) begin
            case ($urandom_range(7))
               0:       cap = 11'd0;
               1:       cap = 11'd1;
               2:       cap = 11'd2;
               3:       cap = 11'd256;
               4:       cap = 11'd1024;
               5:       cap = 11'd2047;
               default: cap = 11'($urandom_range(3, 6));
            endcase
            write_nack_cap(cap);
            next_cap_write = words_sent + 60;
         end
         if ($urandom_range(99) < 80) begin
            send_random_datagram();
         end else begin
            send_noise();
         end
         dgram++;
      end
      idle_pct = 10;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_version_drop();
      test_length_zero();
      test_generic_nack();
      test_short_and_other();
      test_datagram_end();
      test_entry_cap();
      test_random_traffic();

      // Drain: wait for every predicted result, then let stray ones show up.
      push <= 1'b0;
      while (nack_results_due.size() != 0) @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
